### hdl/fpd_pkg.sv
`default_nettype none
// Constants, types and helper functions of the fuzzy power de-rate block.
package fpd_pkg;

	localparam int WEIGHT_FRAC_BITS = 15;
	localparam int MU_W = WEIGHT_FRAC_BITS + 1;
	localparam int MU_ONE = 1 << WEIGHT_FRAC_BITS;

	localparam int OFFS_W = 11;
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W = WEIGHT_FRAC_BITS + 12;
	localparam int PROD_W = RECIP_W + OFFS_W;
	localparam int GRID_SPAN_LOG2 = 11;

	localparam int CABLE_LO = 400;
	localparam int CABLE_MID = 960;
	localparam int CABLE_HI = 1520;
	localparam int CAB_LO = 480;
	localparam int CAB_MID = 960;
	localparam int CAB_HI = 1600;
	localparam int GRID_LO = 0;
	localparam int GRID_MID = 2048;
	localparam int GRID_HI = 4096;

	localparam logic [RECIP_W-1:0] CABLE_RECIP_LOW = RECIP_W'(
		((longint'(1) << (WEIGHT_FRAC_BITS + RECIP_SHIFT)) + (CABLE_MID - CABLE_LO) - 1)
		/ (CABLE_MID - CABLE_LO));
	localparam logic [RECIP_W-1:0] CABLE_RECIP_HIGH = RECIP_W'(
		((longint'(1) << (WEIGHT_FRAC_BITS + RECIP_SHIFT)) + (CABLE_HI - CABLE_MID) - 1)
		/ (CABLE_HI - CABLE_MID));
	localparam logic [RECIP_W-1:0] CAB_RECIP_LOW = RECIP_W'(
		((longint'(1) << (WEIGHT_FRAC_BITS + RECIP_SHIFT)) + (CAB_MID - CAB_LO) - 1)
		/ (CAB_MID - CAB_LO));
	localparam logic [RECIP_W-1:0] CAB_RECIP_HIGH = RECIP_W'(
		((longint'(1) << (WEIGHT_FRAC_BITS + RECIP_SHIFT)) + (CAB_HI - CAB_MID) - 1)
		/ (CAB_HI - CAB_MID));

	localparam int COEF_W = 16;
	localparam int PSUM_W = COEF_W + 4;
	localparam int TOTAL_W = COEF_W + 5;
	localparam logic [COEF_W-1:0] COEF_ONE = 16'd32768;

	typedef logic [MU_W-1:0] mu_t;
	typedef mu_t [2:0] mu3_t;
	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [PSUM_W-1:0] psum_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [2*MU_W-1:0] wprod_t;
	typedef logic [MU_W+COEF_W-1:0] tprod_t;
	typedef logic [PROD_W-1:0] rprod_t;

	typedef enum logic [1:0] {
		REG_LO,
		REG_LOWER_RAMP,
		REG_UPPER_RAMP,
		REG_HI
	} region_t;

	typedef struct packed {
		region_t region;
		logic [OFFS_W-1:0] offs;
	} ramp_t;

	localparam coef_t SINGLETON [27] = '{
		16'd32768, 16'd27853, 16'd18022, 16'd29491, 16'd24576, 16'd14746,
		16'd22938, 16'd18022, 16'd9830,
		16'd27853, 16'd22938, 16'd14746, 16'd24576, 16'd19661, 16'd13107,
		16'd18022, 16'd14746, 16'd8192,
		16'd13107, 16'd9830, 16'd6554, 16'd9830, 16'd8192, 16'd4915,
		16'd6554, 16'd4915, 16'd1638
	};

	function automatic ramp_t classify(logic signed [13:0] x, int lo, int mid, int hi);
		ramp_t r;
		r.region = REG_HI;
		r.offs = '0;
		if (int'(x) <= lo) begin
			r.region = REG_LO;
		end else if (int'(x) < mid) begin
			r.region = REG_LOWER_RAMP;
			r.offs = OFFS_W'(int'(x) - lo);
		end else if (int'(x) < hi) begin
			r.region = REG_UPPER_RAMP;
			r.offs = OFFS_W'(int'(x) - mid);
		end
		return r;
	endfunction

	function automatic mu_t recip_ramp(logic [OFFS_W-1:0] offs, logic [RECIP_W-1:0] recip);
		rprod_t p;
		p = rprod_t'(offs) * rprod_t'(recip);
		return mu_t'(p >> RECIP_SHIFT);
	endfunction

	function automatic mu3_t spread(region_t region, mu_t up);
		mu3_t m;
		m = '0;
		unique case (region)
			REG_LO: m[0] = mu_t'(MU_ONE);
			REG_LOWER_RAMP: begin
				m[1] = up;
				m[0] = mu_t'(MU_ONE) - up;
			end
			REG_UPPER_RAMP: begin
				m[2] = up;
				m[1] = mu_t'(MU_ONE) - up;
			end
			REG_HI: m[2] = mu_t'(MU_ONE);
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

### hdl/fuzzy_power_derate_top.sv
`default_nettype none
// Top level of the fuzzy power de-rate block: seven-stage pipelined Sugeno inference.
//
// Input channel s_*: one word carries a cable temperature, a cabinet
// temperature (both signed, 1/16 degC) and a grid load (signed Q2.12).
// Output channel m_*: one word carries the power coefficient, unsigned
// Q1.15, 32768 meaning full power, one output word per input word, in order.
// A word passes seven registered stages from input handshake to m_tvalid. Stages:
// range detection, membership ramps (reciprocal multiply), pairwise weights,
// triple weights, singleton products, partial sums of nine, final sum and clamp.
// Throughput is one word per cycle while m_tready stays high; the per-stage
// multiplier lanes set that figure.
// Each stage holds a valid bit and advances when the stage after it is empty
// or advancing, so bubbles collapse and s_tready stays high while any stage
// is free, also while a finished word waits at the output.
// When m_tready is low the output word holds and the pipeline fills; s_tready
// drops only once all seven stages hold words.
// arst_n clears all valid bits at once; the block takes words right after.
module fuzzy_power_derate_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [39:0] s_tdata,   // cable_temp[12:0], cabinet_temp[25:13], grid_load[39:26]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [15:0] m_tdata    // power_coefficient[15:0]
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	fpd_pkg::ramp_t c_s1, k_s1, g_s1;
	fpd_pkg::mu3_t mc_s2, mk_s2, mg_s2;
	fpd_pkg::mu3_t mg_s3;
	fpd_pkg::mu_t w2_s3 [9];
	fpd_pkg::mu_t w3_s4 [27];
	fpd_pkg::coef_t term_s5 [27];
	fpd_pkg::psum_t psum_s6 [3];
	fpd_pkg::coef_t coef_s7;

	fpd_pkg::mu_t up_c, up_k, up_g;
	fpd_pkg::mu_t w2_d [9];
	fpd_pkg::mu_t w3_d [27];
	fpd_pkg::coef_t term_d [27];
	fpd_pkg::psum_t psum_d [3];
	fpd_pkg::total_t total_d;
	fpd_pkg::wprod_t wp2 [9];
	fpd_pkg::wprod_t wp3 [27];
	fpd_pkg::tprod_t tp [27];
	logic [fpd_pkg::OFFS_W+fpd_pkg::WEIGHT_FRAC_BITS-1:0] grid_sh;

	function automatic fpd_pkg::mu_t mu_t_low(fpd_pkg::ramp_t r);
		return (r.region == fpd_pkg::REG_LOWER_RAMP)
			? fpd_pkg::recip_ramp(r.offs, fpd_pkg::CABLE_RECIP_LOW)
			: fpd_pkg::recip_ramp(r.offs, fpd_pkg::CABLE_RECIP_HIGH);
	endfunction

	function automatic fpd_pkg::mu_t mu_k_low(fpd_pkg::ramp_t r);
		return (r.region == fpd_pkg::REG_LOWER_RAMP)
			? fpd_pkg::recip_ramp(r.offs, fpd_pkg::CAB_RECIP_LOW)
			: fpd_pkg::recip_ramp(r.offs, fpd_pkg::CAB_RECIP_HIGH);
	endfunction

	assign en7 = !v_s7 || m_tready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;
	assign m_tvalid = v_s7;
	assign m_tdata = coef_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	always_comb begin
		up_c = mu_t_low(c_s1);
		up_k = mu_k_low(k_s1);
		grid_sh = {g_s1.offs, fpd_pkg::WEIGHT_FRAC_BITS'(0)};
		up_g = fpd_pkg::mu_t'(grid_sh >> fpd_pkg::GRID_SPAN_LOG2);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				wp2[i*3+j] = fpd_pkg::wprod_t'(mc_s2[i]) * fpd_pkg::wprod_t'(mk_s2[j]);
				w2_d[i*3+j] = fpd_pkg::mu_t'(wp2[i*3+j] >> fpd_pkg::WEIGHT_FRAC_BITS);
			end
		end
	end

	always_comb begin
		for (int p = 0; p < 9; p++) begin
			for (int g = 0; g < 3; g++) begin
				wp3[p*3+g] = fpd_pkg::wprod_t'(w2_s3[p]) * fpd_pkg::wprod_t'(mg_s3[g]);
				w3_d[p*3+g] = fpd_pkg::mu_t'(wp3[p*3+g] >> fpd_pkg::WEIGHT_FRAC_BITS);
			end
		end
	end

	always_comb begin
		for (int n = 0; n < 27; n++) begin
			tp[n] = fpd_pkg::tprod_t'(w3_s4[n]) * fpd_pkg::tprod_t'(fpd_pkg::SINGLETON[n]);
			term_d[n] = fpd_pkg::coef_t'(tp[n] >> fpd_pkg::WEIGHT_FRAC_BITS);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum_d[i] = '0;
			for (int n = 0; n < 9; n++) begin
				psum_d[i] = psum_d[i] + fpd_pkg::psum_t'(term_s5[i*9+n]);
			end
		end
		total_d = fpd_pkg::total_t'(psum_s6[0]) + fpd_pkg::total_t'(psum_s6[1])
			+ fpd_pkg::total_t'(psum_s6[2]);
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			c_s1 <= fpd_pkg::classify(14'(signed'(s_tdata[12:0])), fpd_pkg::CABLE_LO,
				fpd_pkg::CABLE_MID, fpd_pkg::CABLE_HI);
			k_s1 <= fpd_pkg::classify(14'(signed'(s_tdata[25:13])), fpd_pkg::CAB_LO,
				fpd_pkg::CAB_MID, fpd_pkg::CAB_HI);
			g_s1 <= fpd_pkg::classify(signed'(s_tdata[39:26]), fpd_pkg::GRID_LO,
				fpd_pkg::GRID_MID, fpd_pkg::GRID_HI);
		end
		if (en2 && v_s1) begin
			mc_s2 <= fpd_pkg::spread(c_s1.region, up_c);
			mk_s2 <= fpd_pkg::spread(k_s1.region, up_k);
			mg_s2 <= fpd_pkg::spread(g_s1.region, up_g);
		end
		if (en3 && v_s2) begin
			w2_s3 <= w2_d;
			mg_s3 <= mg_s2;
		end
		if (en4 && v_s3) w3_s4 <= w3_d;
		if (en5 && v_s4) term_s5 <= term_d;
		if (en6 && v_s5) psum_s6 <= psum_d;
		if (en7 && v_s6) begin
			coef_s7 <= (total_d > fpd_pkg::total_t'(fpd_pkg::COEF_ONE))
				? fpd_pkg::COEF_ONE : fpd_pkg::coef_t'(total_d);
		end
	end

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= fpd_pkg::COEF_ONE)
		else $error("coefficient above full power");

	a_cable_unity: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (32'(mc_s2[0]) + 32'(mc_s2[1]) + 32'(mc_s2[2])) == fpd_pkg::MU_ONE)
		else $error("cable memberships do not sum to one");

	a_grid_unity: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (32'(mg_s2[0]) + 32'(mg_s2[1]) + 32'(mg_s2[2])) == fpd_pkg::MU_ONE)
		else $error("grid memberships do not sum to one");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && !m_tready)
		else $error("input stalled with a free stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted word missing from first stage");

endmodule
`default_nettype wire

### dv/tb.sv
`default_nettype none
// Self-checking stream testbench for the fuzzy power de-rate block against a fixed-point predictor.
module tb;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 11;
	localparam int IDLE_MAX = 18;
	localparam int RANDOM_WORDS = 1850;
	localparam int CALM_STRETCH = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NO_WANT = -1;

	localparam int CABLE_LOW_PEAK = 400;
	localparam int CABLE_MID_PEAK = 960;
	localparam int CABLE_HIGH_PEAK = 1520;
	localparam int CABINET_LOW_PEAK = 480;
	localparam int CABINET_MID_PEAK = 960;
	localparam int CABINET_HIGH_PEAK = 1600;
	localparam int GRID_LOW_PEAK = 0;
	localparam int GRID_MID_PEAK = 2048;
	localparam int GRID_HIGH_PEAK = 4096;
	localparam longint GRADE_ONE = longint'(1) << fpd_pkg::WEIGHT_FRAC_BITS;
	localparam longint COEF_FULL = 32768;

	// rule singletons, Q1.15, index [cable][cabinet][grid] flattened
	localparam int RULE_SINGLETON [27] = '{
		32768, 27853, 18022, 29491, 24576, 14746, 22938, 18022, 9830,
		27853, 22938, 14746, 24576, 19661, 13107, 18022, 14746, 8192,
		13107, 9830, 6554, 9830, 8192, 4915, 6554, 4915, 1638
	};

	typedef logic [2:0][31:0] grade3_t;

	typedef struct packed {
		logic signed [12:0] cable;
		logic signed [12:0] cabinet;
		logic signed [13:0] grid;
		logic signed [17:0] want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{13'sd400, 13'sd480, 14'sd0, 18'sd32768},
		'{-13'sd2048, -13'sd2048, -14'sd8192, 18'sd32768},
		'{13'sd1520, 13'sd1600, 14'sd4096, 18'sd1638},
		'{13'sd4095, 13'sd4095, 14'sd8191, 18'sd1638},
		'{13'sd960, 13'sd960, 14'sd2048, 18'sd19661},
		'{13'sd400, 13'sd480, 14'sd4096, 18'sd18022},
		'{13'sd1520, 13'sd480, 14'sd2048, 18'sd9830},
		'{13'sd960, 13'sd1600, 14'sd0, 18'sd18022},
		'{13'sd400, 13'sd1600, 14'sd2048, 18'sd18022},
		'{13'sd1520, 13'sd960, 14'sd0, 18'sd9830},
		'{13'sd960, 13'sd480, 14'sd4096, 18'sd14746},
		'{-13'sd1, -13'sd1, -14'sd1, 18'sd32768},
		'{13'sd401, 13'sd481, 14'sd1, -18'sd1},
		'{13'sd959, 13'sd959, 14'sd2047, -18'sd1},
		'{13'sd961, 13'sd961, 14'sd2049, -18'sd1},
		'{13'sd1519, 13'sd1599, 14'sd4095, -18'sd1},
		'{13'sd680, 13'sd720, 14'sd1024, -18'sd1},
		'{13'sd1240, 13'sd1280, 14'sd3072, -18'sd1},
		'{13'sd0, 13'sd0, -14'sd8192, -18'sd1},
		'{13'sd4095, -13'sd2048, 14'sd8191, -18'sd1},
		'{-13'sd2048, 13'sd4095, 14'sd1, -18'sd1},
		'{13'sd1100, 13'sd1500, 14'sd3900, -18'sd1},
		'{13'sd555, 13'sd1333, -14'sd4096, -18'sd1}
	};

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata;   // cable_temp[12:0], cabinet_temp[25:13], grid_load[39:26]
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;   // power_coefficient[15:0]

	fpd_pkg::coef_t coef_due [$];
	int errors;
	int words_sent;
	int words_checked;
	int cycle_count;
	bit calm;

	fuzzy_power_derate_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic grade3_t grade(int x, int lo, int mid, int hi);
		grade3_t m;
		longint up;
		m = '0;
		if (x <= lo) begin
			m[0] = 32'(GRADE_ONE);
		end else if (x < mid) begin
			up = (longint'(x - lo) << fpd_pkg::WEIGHT_FRAC_BITS) / longint'(mid - lo);
			m[1] = 32'(up);
			m[0] = 32'(GRADE_ONE - up);
		end else if (x < hi) begin
			up = (longint'(x - mid) << fpd_pkg::WEIGHT_FRAC_BITS) / longint'(hi - mid);
			m[2] = 32'(up);
			m[1] = 32'(GRADE_ONE - up);
		end else begin
			m[2] = 32'(GRADE_ONE);
		end
		return m;
	endfunction

	function automatic fpd_pkg::coef_t derate_coef(logic signed [12:0] cable,
			logic signed [12:0] cabinet, logic signed [13:0] grid);
		grade3_t gc;
		grade3_t gk;
		grade3_t gg;
		longint pair_w;
		longint triple_w;
		longint acc;
		gc = grade(int'(cable), CABLE_LOW_PEAK, CABLE_MID_PEAK, CABLE_HIGH_PEAK);
		gk = grade(int'(cabinet), CABINET_LOW_PEAK, CABINET_MID_PEAK, CABINET_HIGH_PEAK);
		gg = grade(int'(grid), GRID_LOW_PEAK, GRID_MID_PEAK, GRID_HIGH_PEAK);
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pair_w = (longint'(gc[i]) * longint'(gk[j])) >> fpd_pkg::WEIGHT_FRAC_BITS;
				for (int g = 0; g < 3; g++) begin
					triple_w = (pair_w * longint'(gg[g])) >> fpd_pkg::WEIGHT_FRAC_BITS;
					acc += (triple_w * longint'(RULE_SINGLETON[i*9 + j*3 + g]))
						>> fpd_pkg::WEIGHT_FRAC_BITS;
				end
			end
		end
		if (acc > COEF_FULL) acc = COEF_FULL;
		return fpd_pkg::coef_t'(acc);
	endfunction

	task automatic send_sample(logic signed [12:0] cable, logic signed [12:0] cabinet,
			logic signed [13:0] grid, int want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {grid, cabinet, cable};
		do @(posedge clk); while (!s_tready);
		coef_due.push_back(want == NO_WANT ? derate_coef(cable, cabinet, grid)
			: fpd_pkg::coef_t'(want));
		words_sent++;
		@(negedge clk);
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(0, IDLE_MAX);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : check_coef
		fpd_pkg::coef_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (coef_due.size() == 0) begin
				$error("power_coefficient: no word expected, got %0d", m_tdata);
				errors++;
			end else begin
				want = coef_due.pop_front();
				words_checked++;
				if (m_tdata !== want) begin
					$error("power_coefficient: expected %0d, actual %0d", want, m_tdata);
					errors++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words outstanding", cycle_count, coef_due.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic signed [12:0] cable;
		logic signed [12:0] cabinet;
		logic signed [13:0] grid;
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_sample(DIRECTED[r].cable, DIRECTED[r].cabinet, DIRECTED[r].grid,
				int'(DIRECTED[r].want));

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			if (k % CALM_STRETCH == 0) calm = ((k / CALM_STRETCH) % 2) == 1;
			if ($urandom_range(0, 3) == 0) begin
				cable = 13'($urandom);
				cabinet = 13'($urandom);
				grid = 14'($urandom);
			end else begin
				cable = 13'($urandom_range(300, 1620));
				cabinet = 13'($urandom_range(380, 1700));
				grid = 14'(int'($urandom_range(0, 4500)) - 200);
			end
			send_sample(cable, cabinet, grid, NO_WANT);
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		wait (coef_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d sensor words sent (%0d directed), %0d coefficients checked,",
			words_sent, DIRECTED_ROWS, words_checked);
		$display("covering peaks, ramps, clamped extremes and random stalls on both channels");
		if (errors == 0 && coef_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

### fuzzy_power_derate_top.f
hdl/fpd_pkg.sv
hdl/fuzzy_power_derate_top.sv
dv/tb.sv
